// File: hdl/smap_pkg.sv
// Types, constants and helpers shared by the STUN mapped-address parser files.
package smap_pkg;

  localparam logic [31:0] COOKIE          = 32'h2112A442;
  localparam logic [15:0] XOR_MAPPED_TYPE = 16'h0020;
  localparam logic [7:0]  FAMILY_IPV4     = 8'h01;
  localparam int          HEADER_BYTES    = 20;
  localparam logic [3:0]  OFFSET_IDLE     = 4'd12;
  localparam logic [16:0] START_MAX       = 17'h1FFFF;
  localparam logic [15:0] MIN_VALUE_LEN   = 16'd8;

  typedef enum logic [1:0] {
    STATUS_FOUND      = 2'd0,
    STATUS_BAD_HEADER = 2'd1,
    STATUS_NO_MAPPED  = 2'd2
  } status_t;

  // Expected cookie byte for packet bytes 4..7, picked by the low two bits.
  function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = COOKIE[31:24];
      2'd1:    b = COOKIE[23:16];
      2'd2:    b = COOKIE[15:8];
      2'd3:    b = COOKIE[7:0];
      default: b = COOKIE[7:0];
    endcase
    return b;
  endfunction

endpackage

// File: hdl/smap_if.sv
// Valid/ready channel interfaces: packet bytes in, parse results out, config write.
interface smap_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface smap_out_if;
  logic             valid;
  logic             ready;
  smap_pkg::status_t status;
  logic [15:0]      mapped_port;
  logic [31:0]      mapped_address;
  logic             address_changed;

  modport source (output valid, output status, output mapped_port, output mapped_address,
                  output address_changed, input ready);
  modport sink   (input valid, input status, input mapped_port, input mapped_address,
                  input address_changed, output ready);
endinterface

interface smap_cfg_if;
  logic valid;
  logic ready;
  logic pad_to_four;

  modport source (output valid, output pad_to_four, input ready);
  modport sink   (input valid, input pad_to_four, output ready);
endinterface

// File: hdl/stun_mapped_address_parser.sv
// Top level: byte-serial STUN response parser that extracts the XOR-mapped IPv4 address.
//
//   channel  dir  fields                                                 beat
//   cfg      in   pad_to_four                                            valid & ready
//   pkt      in   data_byte, last_byte                                   valid & ready
//   res      out  status, mapped_port, mapped_address, address_changed   valid & ready
//
// One byte per cycle while pkt.ready is high: each accepted byte updates the parse state in the same cycle.
// A byte marked last loads the result register; the result shows in the following cycle.
// pkt.ready drops only in reset or while a result waits and res.ready is low (one-entry output register).
// Synchronous reset clears the parse state and stored public address and sets pad_to_four to 1.
// Bytes at position 2**POSITION_BITS-1 and beyond are not parsed; only their last mark
// is obeyed.
module stun_mapped_address_parser #(
  parameter int POSITION_BITS = 16
) (
  input logic       clk,
  input logic       rst,
  smap_cfg_if.sink  cfg,
  smap_in_if.sink   pkt,
  smap_out_if.source res
);

  localparam logic [POSITION_BITS-1:0] POS_MAX   = '1;
  localparam logic [POSITION_BITS-1:0] HDR_BYTES = POSITION_BITS'(smap_pkg::HEADER_BYTES);
  localparam logic [16:0]              HDR_START = 17'(smap_pkg::HEADER_BYTES);

  logic                     pad_to_four;
  logic [POSITION_BITS-1:0] byte_position;
  logic [16:0]              next_attribute_start;
  logic                     cookie_ok;
  logic [31:0]              attribute_header;
  logic [7:0]               candidate_family;
  logic [47:0]              captured_port_address;
  logic                     found_mapped;
  logic [47:0]              stored_public_address;
  logic [3:0]               attr_offset;
  logic                     res_valid;

  logic [POSITION_BITS-1:0] byte_position_next;
  logic [16:0]              next_attribute_start_next;
  logic                     cookie_ok_next;
  logic [31:0]              attribute_header_next;
  logic [7:0]               candidate_family_next;
  logic [47:0]              captured_port_address_next;
  logic                     found_mapped_next;
  logic [3:0]               attr_offset_next;

  logic                     at_start;
  logic [3:0]               eff_offset;
  logic [15:0]              raw_len;
  logic [16:0]              pad_len;
  logic [17:0]              next_start_sum;
  logic                     candidate;
  logic [47:0]              decoded;
  smap_pkg::status_t        status_next;

  logic                     pkt_beat;
  logic                     cfg_beat;

  assign pkt.ready = !rst && (!res_valid || res.ready);
  assign cfg.ready = !rst;
  assign pkt_beat  = pkt.valid && pkt.ready;
  assign cfg_beat  = cfg.valid && cfg.ready;
  assign res.valid = res_valid;

  always_comb begin
    byte_position_next         = byte_position;
    next_attribute_start_next  = next_attribute_start;
    cookie_ok_next             = cookie_ok;
    attribute_header_next      = attribute_header;
    candidate_family_next      = candidate_family;
    captured_port_address_next = captured_port_address;
    found_mapped_next          = found_mapped;
    attr_offset_next           = attr_offset;
    at_start                   = 1'b0;
    eff_offset                 = attr_offset;
    raw_len                    = '0;
    pad_len                    = '0;
    next_start_sum             = '0;
    candidate                  = 1'b0;

    if (byte_position != POS_MAX) begin
      byte_position_next = byte_position + POSITION_BITS'(1);
      if (byte_position >= POSITION_BITS'(4) && byte_position <= POSITION_BITS'(7) &&
          pkt.data_byte != smap_pkg::cookie_byte(byte_position[1:0])) begin
        cookie_ok_next = 1'b0;
      end
      at_start   = {{(17-POSITION_BITS){1'b0}}, byte_position} == next_attribute_start;
      eff_offset = at_start ? 4'd0 : attr_offset;
      if (eff_offset < smap_pkg::OFFSET_IDLE) begin
        attr_offset_next = eff_offset + 4'd1;
        if (eff_offset < 4'd4) begin
          attribute_header_next = {attribute_header[23:0], pkt.data_byte};
          if (eff_offset == 4'd3) begin
            // Attribute header complete: locate the next one, decide whether to capture.
            raw_len        = attribute_header_next[15:0];
            pad_len        = pad_to_four ? (({1'b0, raw_len} + 17'd3) & ~17'd3)
                                         : {1'b0, raw_len};
            next_start_sum = {{(18-POSITION_BITS){1'b0}}, byte_position} + 18'd1
                             + {1'b0, pad_len};
            next_attribute_start_next = (next_start_sum > {1'b0, smap_pkg::START_MAX})
                                        ? smap_pkg::START_MAX : next_start_sum[16:0];
            candidate = (attribute_header_next[31:16] == smap_pkg::XOR_MAPPED_TYPE) &&
                        !found_mapped && (raw_len >= smap_pkg::MIN_VALUE_LEN);
            if (!candidate) begin
              attr_offset_next = smap_pkg::OFFSET_IDLE;
            end
          end
        end else if (eff_offset == 4'd5) begin
          candidate_family_next = pkt.data_byte;
        end else if (eff_offset >= 4'd6) begin
          captured_port_address_next = {captured_port_address[39:0], pkt.data_byte};
          if (eff_offset == 4'd11 && candidate_family == smap_pkg::FAMILY_IPV4) begin
            found_mapped_next = 1'b1;
          end
        end
      end
    end

    decoded = {captured_port_address_next[47:32] ^ smap_pkg::COOKIE[31:16],
               captured_port_address_next[31:0] ^ smap_pkg::COOKIE};
    if (!cookie_ok_next || byte_position_next < HDR_BYTES) begin
      status_next = smap_pkg::STATUS_BAD_HEADER;
    end else if (!found_mapped_next) begin
      status_next = smap_pkg::STATUS_NO_MAPPED;
    end else begin
      status_next = smap_pkg::STATUS_FOUND;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pad_to_four           <= 1'b1;
      stored_public_address <= '0;
      byte_position         <= '0;
      next_attribute_start  <= HDR_START;
      cookie_ok             <= 1'b1;
      attribute_header      <= '0;
      candidate_family      <= '0;
      captured_port_address <= '0;
      found_mapped          <= 1'b0;
      attr_offset           <= smap_pkg::OFFSET_IDLE;
      res_valid             <= 1'b0;
    end else begin
      if (cfg_beat) begin
        pad_to_four <= cfg.pad_to_four;
      end
      if (pkt_beat && pkt.last_byte) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
      if (pkt_beat) begin
        if (pkt.last_byte) begin
          // Rearm for the next packet.
          byte_position         <= '0;
          next_attribute_start  <= HDR_START;
          cookie_ok             <= 1'b1;
          attribute_header      <= '0;
          candidate_family      <= '0;
          captured_port_address <= '0;
          found_mapped          <= 1'b0;
          attr_offset           <= smap_pkg::OFFSET_IDLE;
          if (status_next == smap_pkg::STATUS_FOUND) begin
            stored_public_address <= decoded;
          end
        end else begin
          byte_position         <= byte_position_next;
          next_attribute_start  <= next_attribute_start_next;
          cookie_ok             <= cookie_ok_next;
          attribute_header      <= attribute_header_next;
          candidate_family      <= candidate_family_next;
          captured_port_address <= captured_port_address_next;
          found_mapped          <= found_mapped_next;
          attr_offset           <= attr_offset_next;
        end
      end
    end
  end

  // Result payload; zero fields unless an address was found.
  always_ff @(posedge clk) begin
    if (pkt_beat && pkt.last_byte) begin
      res.status <= status_next;
      if (status_next == smap_pkg::STATUS_FOUND) begin
        res.mapped_port     <= decoded[47:32];
        res.mapped_address  <= decoded[31:0];
        res.address_changed <= decoded != stored_public_address;
      end else begin
        res.mapped_port     <= '0;
        res.mapped_address  <= '0;
        res.address_changed <= 1'b0;
      end
    end
  end

endmodule

// File: hdl/smap_checker.sv
// Port-level assertions for the STUN mapped-address parser, bound to the top level.
module smap_checker (
  input logic              clk,
  input logic              rst,
  input logic              pkt_valid,
  input logic              pkt_ready,
  input logic              pkt_last,
  input logic              res_valid,
  input logic              res_ready,
  input smap_pkg::status_t res_status,
  input logic [15:0]       res_port,
  input logic [31:0]       res_address,
  input logic              res_changed
);

  // A stalled result holds.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_status) && $stable(res_port) &&
                                $stable(res_address) && $stable(res_changed))
    else $error("result changed while stalled");

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    pkt_valid && pkt_ready && pkt_last |=> res_valid)
    else $error("last beat gave no result");

  a_inner_no_result: assert property (@(posedge clk) disable iff (rst)
    pkt_valid && pkt_ready && !pkt_last |=> !res_valid)
    else $error("result without a last beat");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status != smap_pkg::STATUS_FOUND |->
      res_port == 16'd0 && res_address == 32'd0 && !res_changed)
    else $error("nonzero fields on a failed parse");

endmodule

bind stun_mapped_address_parser smap_checker u_smap_checker (
  .clk         (clk),
  .rst         (rst),
  .pkt_valid   (pkt.valid),
  .pkt_ready   (pkt.ready),
  .pkt_last    (pkt.last_byte),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .res_status  (res.status),
  .res_port    (res.mapped_port),
  .res_address (res.mapped_address),
  .res_changed (res.address_changed)
);
